// ===== hdl/bcp_pkg.sv =====
// shared types and constants for the binomial coefficient block
// no dependencies
package bcp_pkg;

   localparam int CountW = 7;
   localparam int CoefW  = 63;

   localparam logic [CoefW-1:0] CoefOne = CoefW'(1);
   localparam logic [CoefW-1:0] CoefSat = {CoefW{1'b1}};

   typedef struct packed {
      logic             valid;
      logic [CoefW-1:0] coefficient;
      logic             k_exceeds_n;
   } result_type;

endpackage

// ===== hdl/bcp_row_mem.sv =====
// scratch row store for pascal's triangle: one write port, two registered read ports
// depends on bcp_pkg
module bcp_row_mem #(
   parameter int Depth = 67,
   parameter int AddrW = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AddrW-1:0]          wr_addr,
   input  logic [bcp_pkg::CoefW-1:0] wr_data,
   input  logic [AddrW-1:0]          rd_addr_a,
   input  logic [AddrW-1:0]          rd_addr_b,
   output logic [bcp_pkg::CoefW-1:0] rd_data_a,
   output logic [bcp_pkg::CoefW-1:0] rd_data_b
);
   import bcp_pkg::*;

   logic [CoefW-1:0] mem_ff [Depth];
   logic [CoefW-1:0] rd_data_a_ff;
   logic [CoefW-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/bcp_seq.sv =====
// sequencer and shared adder that fill the pascal row in place, high index down
// depends on bcp_pkg; drives the ports of bcp_row_mem
module bcp_seq #(
   parameter int N_MAX = 66,
   localparam int AddrW = $clog2(N_MAX + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_go,
   input  logic [bcp_pkg::CountW-1:0] total_count,
   input  logic [bcp_pkg::CountW-1:0] chosen_count,
   output logic                       busy,
   input  logic                       out_free,
   output bcp_pkg::result_type        result,
   output logic                       wr_en,
   output logic [AddrW-1:0]           wr_addr,
   output logic [bcp_pkg::CoefW-1:0]  wr_data,
   output logic [AddrW-1:0]           rd_addr_a,
   output logic [AddrW-1:0]           rd_addr_b,
   input  logic [bcp_pkg::CoefW-1:0]  rd_data_a,
   input  logic [bcp_pkg::CoefW-1:0]  rd_data_b
);
   import bcp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_ROW,
      S_GAP,
      S_READ,
      S_CAPTURE,
      S_FIN
   } state_type;

   state_type         state_ff;
   logic [CountW-1:0] n_ff;
   logic [CountW-1:0] k_ff;
   logic [CountW-1:0] i_ff;
   logic [CountW-1:0] j_ff;
   logic              pend_ff;
   logic [CountW-1:0] pend_j_ff;
   logic              pend_edge_ff;
   logic [CoefW-1:0]  coef_ff;
   logic              flag_ff;
   logic [CountW-1:0] i_next_in;
   logic [CoefW-1:0]  sum_in;

   assign i_next_in = i_ff + CountW'(1);
   assign sum_in    = rd_data_a + rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_ROW);
         unique case (state_ff)
            S_IDLE: begin
               if (req_go) begin
                  n_ff <= total_count;
                  k_ff <= chosen_count;
                  if (chosen_count > total_count) begin
                     coef_ff  <= '0;
                     flag_ff  <= 1'b1;
                     state_ff <= S_FIN;
                  end else if (total_count > CountW'(N_MAX)) begin
                     coef_ff  <= CoefSat;
                     flag_ff  <= 1'b0;
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_INIT;
                  end
               end
            end
            S_INIT: begin
               // entry zero is written this cycle; k of zero needs no rows
               i_ff <= CountW'(1);
               j_ff <= CountW'(1);
               if (k_ff == '0) begin
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               pend_j_ff    <= j_ff;
               pend_edge_ff <= (j_ff == i_ff);
               if (j_ff == CountW'(1)) begin
                  state_ff <= S_GAP;
               end else begin
                  j_ff <= j_ff - CountW'(1);
               end
            end
            S_GAP: begin
               // last write of the row lands here, before the next row reads
               if (i_ff == n_ff) begin
                  state_ff <= S_READ;
               end else begin
                  i_ff     <= i_next_in;
                  j_ff     <= (i_next_in < k_ff) ? i_next_in : k_ff;
                  state_ff <= S_ROW;
               end
            end
            S_READ: begin
               state_ff <= S_CAPTURE;
            end
            S_CAPTURE: begin
               coef_ff  <= rd_data_a;
               flag_ff  <= 1'b0;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rd_addr_a = (state_ff == S_READ) ? AddrW'(k_ff) : AddrW'(j_ff);
   assign rd_addr_b = AddrW'(j_ff - CountW'(1));

   assign wr_en   = (state_ff == S_INIT) || pend_ff;
   assign wr_addr = (state_ff == S_INIT) ? '0 : AddrW'(pend_j_ff);
   assign wr_data = ((state_ff == S_INIT) || pend_edge_ff) ? CoefOne : sum_in;

   assign busy               = (state_ff != S_IDLE);
   assign result.valid       = (state_ff == S_FIN);
   assign result.coefficient = coef_ff;
   assign result.k_exceeds_n = flag_ff;

`ifndef NO_ASSERTIONS
   a_row_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROW |-> j_ff != '0 && j_ff <= i_ff && i_ff <= n_ff)
      else $error("row index out of range");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROW |-> n_ff <= CountW'(N_MAX) && j_ff <= k_ff)
      else $error("row walk beyond bound");

   a_write_src: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != S_INIT |-> $past(state_ff == S_ROW))
      else $error("row write without a preceding issue");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && flag_ff |-> coef_ff == '0)
      else $error("flagged result with nonzero coefficient");
`endif

endmodule

// ===== hdl/binomial_coefficient_pascal_top.sv =====
// channel | dir | ports                                      | accepted when
// req     | in  | req_valid req_stall req_total_count/chosen | req_valid && !req_stall
// rsp     | out | rsp_valid rsp_stall rsp_coefficient/k_exc. | rsp_valid && !rsp_stall
// one request walks rows 1 to n of the triangle (none when k is zero), each row from entry
// min(row, k) down to entry 1, paced by the single adder and the two-read, one-write row
// store. k > n or n > N_MAX skip the row walk.
// reset is synchronous; no clearing pass. a finished result waits in the output register
// while the next request is taken; req_stall is high while a request is in work.
// depends on bcp_pkg, bcp_row_mem, bcp_seq
module binomial_coefficient_pascal_top #(
   parameter int N_MAX = 66
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [bcp_pkg::CountW-1:0] req_total_count,
   input  logic [bcp_pkg::CountW-1:0] req_chosen_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [bcp_pkg::CoefW-1:0]  rsp_coefficient,
   output logic                       rsp_k_exceeds_n
);
   import bcp_pkg::*;

   localparam int Depth = N_MAX + 1;
   localparam int AddrW = $clog2(Depth);

   logic              busy;
   logic              req_go;
   logic              out_free;
   result_type        result;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [CoefW-1:0]  wr_data;
   logic [AddrW-1:0]  rd_addr_a;
   logic [AddrW-1:0]  rd_addr_b;
   logic [CoefW-1:0]  rd_data_a;
   logic [CoefW-1:0]  rd_data_b;
   logic              rsp_valid_ff;
   logic [CoefW-1:0]  rsp_coefficient_ff;
   logic              rsp_k_exceeds_n_ff;

   assign req_stall = busy;
   assign req_go    = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bcp_seq #(
      .N_MAX (N_MAX)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_go       (req_go),
      .total_count  (req_total_count),
      .chosen_count (req_chosen_count),
      .busy         (busy),
      .out_free     (out_free),
      .result       (result),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_data_a    (rd_data_a),
      .rd_data_b    (rd_data_b)
   );

   bcp_row_mem #(
      .Depth (Depth),
      .AddrW (AddrW)
   ) u_row_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // output register parts the result side from the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && out_free) begin
         rsp_valid_ff       <= 1'b1;
         rsp_coefficient_ff <= result.coefficient;
         rsp_k_exceeds_n_ff <= result.k_exceeds_n;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_k_exceeds_n = rsp_k_exceeds_n_ff;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for binomial_coefficient_pascal_top: directed, random and
// back-pressure requests checked against an in-bench pascal triangle predictor
// depends on bcp_pkg and the binomial_coefficient_pascal_top rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcp_pkg::*;

   localparam int NMax       = 66;
   localparam int CycleLimit = 4_000_000;
   localparam int TailCycles = 50;
   localparam int HoldCycles = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CountW-1:0]   req_total_count = '0;
   logic [CountW-1:0]   req_chosen_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CoefW-1:0]    rsp_coefficient;
   logic                rsp_k_exceeds_n;

   // predictor copy of the scratch row
   logic [CoefW-1:0]    tri_row [0:NMax];

   result_type          coef_expected_q [$];
   bit                  idle_enable = 1'b1;
   bit                  hold_active = 1'b0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  request_count = 0;
   int                  over_count = 0;
   int                  sat_count = 0;
   int                  result_count = 0;

   binomial_coefficient_pascal_top #(.N_MAX(NMax)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_total_count  (req_total_count),
      .req_chosen_count (req_chosen_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_k_exceeds_n  (rsp_k_exceeds_n)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  coef_expected_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic result_type predict_coefficient(input logic [CountW-1:0] n,
                                                      input logic [CountW-1:0] k);
      result_type r;
      int         i;
      int         j;
      int         top;
      r.valid       = 1'b1;
      r.coefficient = '0;
      r.k_exceeds_n = 1'b0;
      if (k > n) begin
         r.k_exceeds_n = 1'b1;
      end else if (n > NMax) begin
         r.coefficient = CoefSat;
      end else begin
         tri_row[0] = CoefOne;
         for (i = 1; i <= int'(n); i++) begin
            top = (i < int'(k)) ? i : int'(k);
            // in-place update from the high index down
            for (j = top; j >= 1; j--) begin
               if (j == i) begin
                  tri_row[j] = CoefOne;
               end else begin
                  tri_row[j] = tri_row[j] + tri_row[j-1];
               end
            end
         end
         r.coefficient = tri_row[k];
      end
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge after acceptance
   task automatic send_request(input logic [CountW-1:0] n, input logic [CountW-1:0] k);
      result_type r;
      while (idle_enable && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_total_count  <= n;
      req_chosen_count <= k;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = predict_coefficient(n, k);
      coef_expected_q = {coef_expected_q, r};
      request_count++;
      if (r.k_exceeds_n) over_count++;
      else if (n > NMax) sat_count++;
      @(negedge clock);
   endtask

   // flag changes land on a rising edge so the stall driver sees them cleanly
   task automatic set_idling(input bit on);
      req_valid <= 1'b0;
      @(posedge clock);
      idle_enable = on;
      @(negedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_active = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= hold_active || (idle_enable && $urandom_range(0, 99) < 8);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         result_count++;
         if (coef_expected_q.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: coefficient %0d k_exceeds_n %0b",
                        rsp_coefficient, rsp_k_exceeds_n);
            error_count++;
         end else begin
            want = coef_expected_q.pop_front();
            if (rsp_coefficient !== want.coefficient ||
                rsp_k_exceeds_n !== want.k_exceeds_n) begin
               if (error_count < 10)
                  $display("mismatch: expected coefficient %0d k_exceeds_n %0b, got %0d %0b",
                           want.coefficient, want.k_exceeds_n,
                           rsp_coefficient, rsp_k_exceeds_n);
               error_count++;
            end
         end
      end
   end

   task automatic test_edges();
      send_request(0, 0);
      send_request(1, 0);
      send_request(1, 1);
      send_request(2, 1);
      send_request(10, 5);
      send_request(66, 0);
      send_request(66, 66);
      send_request(66, 65);
      send_request(66, 33);
      send_request(65, 32);
      send_request(64, 64);
      // chosen above total
      send_request(0, 1);
      send_request(5, 127);
      send_request(67, 68);
      send_request(126, 127);
      // total above bound with chosen in range
      send_request(67, 3);
      send_request(127, 0);
      send_request(127, 127);
      send_request(127, 126);
      send_request(85, 42);
   endtask

   task automatic test_back_to_back();
      logic [CountW-1:0] n;
      int                i;
      set_idling(1'b0);
      for (i = 0; i < 20; i++) begin
         n = CountW'($urandom_range(0, 12));
         send_request(n, CountW'($urandom_range(0, 13)));
      end
      set_idling(1'b1);
   endtask

   task automatic test_backpressure();
      logic [CountW-1:0] n;
      int                i;
      fork
         hold_receiver(HoldCycles);
      join_none
      // results pile up until the block stalls its input
      for (i = 0; i < 12; i++) begin
         n = CountW'($urandom_range(0, 6));
         send_request(n, CountW'($urandom_range(0, 7)));
      end
   endtask

   task automatic test_random(input int count);
      logic [CountW-1:0] n;
      logic [CountW-1:0] k;
      int                pick;
      int                i;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = CountW'($urandom_range(0, 16));
            k = CountW'($urandom_range(0, n));
         end else if (pick < 78) begin
            n = CountW'($urandom_range(40, NMax));
            k = CountW'($urandom_range(0, n));
         end else if (pick < 88) begin
            n = CountW'($urandom_range(0, 126));
            k = CountW'($urandom_range(n + 1, 127));
         end else begin
            n = CountW'($urandom_range(NMax + 1, 127));
            k = CountW'($urandom_range(0, 127));
         end
         send_request(n, k);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edges();
      test_back_to_back();
      test_backpressure();
      test_random(208);

      req_valid <= 1'b0;
      while (coef_expected_q.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("%0d requests, %0d results checked, %0d with chosen above total,",
               request_count, result_count, over_count);
      $display("%0d above the row bound, one receiver hold of %0d cycles",
               sat_count, HoldCycles);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", error_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
